/* src/kdtc_pkg.sv */
// ----------------------------------------------------------------------------
// kdtc_pkg
// Shared constants and register map of the key double-tap / chord detector.
// ----------------------------------------------------------------------------
package kdtc_pkg;

    localparam int KEY_COUNT = 256;
    localparam int KEY_AW    = $clog2(KEY_COUNT);

    localparam int CODE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int WINDOW_W  = 16;
    localparam int HANDLE_W  = 64;

    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [CODE_W-1:0]   NO_KEY         = 8'd255;
    localparam logic [CODE_W-1:0]   IGNORE_LO      = 8'd16;
    localparam logic [CODE_W-1:0]   IGNORE_HI      = 8'd18;
    localparam logic [WINDOW_W-1:0] TAP_WINDOW_RST = 16'd500;

    localparam logic MODE_TAP   = 1'b0;
    localparam logic MODE_CHORD = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_DETECT_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TAP_KEY     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHORD_ONE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CHORD_TWO   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CHORD_THREE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TAP_WINDOW  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_A    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_B    = 3'd7;

    localparam int CHORD_N = 3;

    typedef logic [CHORD_N-1:0] chord_slot_t;

endpackage

/* src/kdtc_ram.sv */
// ----------------------------------------------------------------------------
// kdtc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module kdtc_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/key_double_tap_and_chord_detector.sv */
// ----------------------------------------------------------------------------
// key_double_tap_and_chord_detector
// Takes one key event word per cycle while s_ready is high and returns one
// result word per event via stage 1 and the output register. The held-key
// bitmap sits in a RAM with a registered read: each event reads its key's
// bit on acceptance and writes it back as it leaves stage 1, with a one-deep
// forward for back-to-back events on the same key. After reset a clearing
// pass over all KEY_COUNT (256) addresses holds s_ready low. Writing a chord
// key register holds s_ready low while the key's held bit goes to its shadow flop.
// ----------------------------------------------------------------------------
module key_double_tap_and_chord_detector import kdtc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CODE_W-1:0]   s_key_code,
    input  logic                s_key_down,
    input  logic [TIME_W-1:0]   s_time_ms,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_fire,
    output logic [HANDLE_W-1:0] m_target_handle
);

    // configuration
    logic                detect_mode_reg;
    logic [CODE_W-1:0]   tap_key_reg;
    logic [CODE_W-1:0]   chord_key_reg [CHORD_N];
    logic [WINDOW_W-1:0] tap_window_reg;
    logic [HANDLE_W-1:0] target_a_reg;
    logic [HANDLE_W-1:0] target_b_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    // clearing pass
    logic              clr_active_reg;
    logic [KEY_AW-1:0] clr_addr_reg;

    // chord held-bit refresh
    chord_slot_t       refresh_pend_reg;
    chord_slot_t       refresh_wait_reg;
    logic              refresh_ok_reg;
    logic              refresh_ok_next;
    logic [CODE_W-1:0] refresh_key;
    chord_slot_t       refresh_pend_next;

    // stage 1
    logic              s1_valid_reg;
    logic [CODE_W-1:0] s1_code_reg;
    logic              s1_down_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic              s1_adv;
    logic              s_accept;

    // forward of the last bitmap write
    logic              fwd_valid_reg;
    logic [KEY_AW-1:0] fwd_addr_reg;
    logic              fwd_data_reg;

    // detection state
    logic [CODE_W-1:0] hist_reg [CHORD_N];
    logic [TIME_W-1:0] last_time_reg;
    logic              sel_reg;
    logic              chord_held_reg [CHORD_N];

    // RAM ports
    logic              ram_we;
    logic [KEY_AW-1:0] ram_waddr;
    logic              ram_wdata;
    logic              ram_re;
    logic [KEY_AW-1:0] ram_raddr;
    logic              ram_rdata;

    // stage 1 decode
    logic              s1_ignored;
    logic              s1_in_range;
    logic              s1_active;
    logic [KEY_AW-1:0] s1_addr;
    logic              held_old;
    logic              new_press;
    logic              chord_hit [CHORD_N];
    logic              chord_now [CHORD_N];
    logic [TIME_W-1:0] tap_diff;
    logic              tap_hit;
    logic              two_hit;
    logic              three_hit;
    logic              trig;
    logic [HANDLE_W-1:0] sel_handle;
    logic              fire;

    logic                m_valid_reg;
    logic                m_fire_reg;
    logic [HANDLE_W-1:0] m_handle_reg;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:3];

    always_comb begin
        case (reg_idx)
            REG_DETECT_MODE: prdata = {{(APB_DW-1){1'b0}}, detect_mode_reg};
            REG_TAP_KEY:     prdata = {{(APB_DW-CODE_W){1'b0}}, tap_key_reg};
            REG_CHORD_ONE:   prdata = {{(APB_DW-CODE_W){1'b0}}, chord_key_reg[0]};
            REG_CHORD_TWO:   prdata = {{(APB_DW-CODE_W){1'b0}}, chord_key_reg[1]};
            REG_CHORD_THREE: prdata = {{(APB_DW-CODE_W){1'b0}}, chord_key_reg[2]};
            REG_TAP_WINDOW:  prdata = {{(APB_DW-WINDOW_W){1'b0}}, tap_window_reg};
            REG_TARGET_A:    prdata = target_a_reg;
            REG_TARGET_B:    prdata = target_b_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_mode_reg  <= MODE_TAP;
            tap_key_reg      <= NO_KEY;
            chord_key_reg[0] <= NO_KEY;
            chord_key_reg[1] <= NO_KEY;
            chord_key_reg[2] <= NO_KEY;
            tap_window_reg   <= TAP_WINDOW_RST;
            target_a_reg     <= '0;
            target_b_reg     <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DETECT_MODE: detect_mode_reg  <= pwdata[0];
                REG_TAP_KEY:     tap_key_reg      <= pwdata[CODE_W-1:0];
                REG_CHORD_ONE:   chord_key_reg[0] <= pwdata[CODE_W-1:0];
                REG_CHORD_TWO:   chord_key_reg[1] <= pwdata[CODE_W-1:0];
                REG_CHORD_THREE: chord_key_reg[2] <= pwdata[CODE_W-1:0];
                REG_TAP_WINDOW:  tap_window_reg   <= pwdata[WINDOW_W-1:0];
                REG_TARGET_A:    target_a_reg     <= pwdata;
                REG_TARGET_B:    target_b_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Chord key refresh: fetch the held bit of a newly written chord key.
    // During the clearing pass every key reads as released, so skip it.
    // ------------------------------------------------------------------
    always_comb begin
        refresh_pend_next = '0;
        if (cfg_wr && !clr_active_reg) begin
            case (reg_idx)
                REG_CHORD_ONE:   refresh_pend_next = 3'b001;
                REG_CHORD_TWO:   refresh_pend_next = 3'b010;
                REG_CHORD_THREE: refresh_pend_next = 3'b100;
                default:         refresh_pend_next = '0;
            endcase
        end
    end

    always_comb begin
        refresh_key = chord_key_reg[0];
        if (refresh_pend_reg[1]) begin
            refresh_key = chord_key_reg[1];
        end else if (refresh_pend_reg[2]) begin
            refresh_key = chord_key_reg[2];
        end
    end

    assign refresh_ok_next = {1'b0, refresh_key} < (CODE_W+1)'(KEY_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_pend_reg <= '0;
            refresh_wait_reg <= '0;
            refresh_ok_reg   <= 1'b0;
        end else begin
            refresh_pend_reg <= refresh_pend_next;
            refresh_wait_reg <= refresh_pend_reg;
            refresh_ok_reg   <= refresh_ok_next;
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == KEY_AW'(KEY_COUNT - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake and held-key RAM
    // ------------------------------------------------------------------
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clr_active_reg && !(|refresh_pend_reg) && !(|refresh_wait_reg)
                      && (!s1_valid_reg || s1_adv);
    assign s_accept = s_valid && s_ready;

    assign ram_re    = s_accept || (|refresh_pend_reg);
    assign ram_raddr = (|refresh_pend_reg) ? refresh_key[KEY_AW-1:0]
                                           : s_key_code[KEY_AW-1:0];
    assign ram_we    = clr_active_reg || (s1_adv && s1_active);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr;
    assign ram_wdata = clr_active_reg ? 1'b0 : s1_down_reg;

    kdtc_ram #(
        .WIDTH (1),
        .DEPTH (KEY_COUNT)
    ) u_held_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_code_reg <= s_key_code;
            s1_down_reg <= s_key_down;
            s1_time_reg <= s_time_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s1_adv && s1_active) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_active) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= s1_down_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decode and detection
    // ------------------------------------------------------------------
    always_comb begin
        s1_ignored  = s1_code_reg inside {[IGNORE_LO:IGNORE_HI]};
        s1_in_range = {1'b0, s1_code_reg} < (CODE_W+1)'(KEY_COUNT);
        s1_active   = s1_valid_reg && !s1_ignored && s1_in_range;
        s1_addr     = s1_code_reg[KEY_AW-1:0];
        held_old    = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : ram_rdata;
        new_press   = s1_active && s1_down_reg && !held_old;
    end

    always_comb begin
        for (int j = 0; j < CHORD_N; j++) begin
            chord_hit[j] = s1_code_reg == chord_key_reg[j];
            chord_now[j] = chord_hit[j] || chord_held_reg[j];
        end
    end

    always_comb begin
        tap_diff  = s1_time_reg - last_time_reg;
        tap_hit   = (tap_diff < {{(TIME_W-WINDOW_W){1'b0}}, tap_window_reg})
                    && hist_reg[2] == s1_code_reg && s1_code_reg == tap_key_reg;
        // two-key form: match on the older or the newer pair, fires once
        two_hit   = chord_now[0] && chord_now[1]
                    && ((hist_reg[1] == chord_key_reg[0] && hist_reg[2] == chord_key_reg[1])
                     || (hist_reg[2] == chord_key_reg[0] && chord_hit[1]));
        three_hit = hist_reg[1] == chord_key_reg[0] && hist_reg[2] == chord_key_reg[1]
                    && chord_hit[2] && chord_now[0] && chord_now[1] && chord_now[2];
        if (detect_mode_reg == MODE_TAP) begin
            trig = new_press && tap_hit;
        end else if (chord_key_reg[2] == NO_KEY) begin
            trig = new_press && two_hit;
        end else begin
            trig = new_press && three_hit;
        end
        sel_handle = sel_reg ? target_b_reg : target_a_reg;
        fire       = trig && (sel_handle != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg[0]   <= '0;
            hist_reg[1]   <= '0;
            hist_reg[2]   <= '0;
            last_time_reg <= '0;
            sel_reg       <= 1'b0;
        end else if (s1_adv && new_press) begin
            if (trig) begin
                hist_reg[0] <= '0;
                hist_reg[1] <= '0;
                hist_reg[2] <= '0;
            end else begin
                hist_reg[0] <= hist_reg[1];
                hist_reg[1] <= hist_reg[2];
                hist_reg[2] <= s1_code_reg;
            end
            if (detect_mode_reg == MODE_TAP) begin
                last_time_reg <= s1_time_reg;
            end
            if (fire) begin
                sel_reg <= !sel_reg;
            end
        end
    end

    // shadow held bits of the chord keys
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < CHORD_N; j++) begin
                chord_held_reg[j] <= 1'b0;
            end
        end else begin
            for (int j = 0; j < CHORD_N; j++) begin
                if (refresh_wait_reg[j]) begin
                    chord_held_reg[j] <= ram_rdata && refresh_ok_reg;
                end else if (s1_adv && s1_active && chord_hit[j]) begin
                    chord_held_reg[j] <= s1_down_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_fire_reg   <= fire;
            m_handle_reg <= fire ? sel_handle : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_fire          = m_fire_reg;
    assign m_target_handle = m_handle_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_accept)
        else $error("word accepted during clearing pass");

    a_refresh_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (|refresh_wait_reg) |-> !s1_valid_reg)
        else $error("chord refresh overlaps an event in flight");

    a_fire_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fire == (m_target_handle != '0)))
        else $error("fire and target handle disagree");

    a_sel_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (sel_reg != $past(sel_reg)) |-> (m_valid_reg && m_fire_reg))
        else $error("target selection changed without a fire");

endmodule
